// ----- hdl/pcrd_pkg.sv -----
// types, constants and codes shared by the run-length sprite decoder
package pcrd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned DIM_W           = 10;
  localparam int unsigned COL_W           = 11;
  localparam int unsigned RUN_W           = 6;
  localparam int unsigned IDX_OUT_W       = 20;
  localparam int unsigned SIZE_W          = 2 * DIM_W;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned MAX_DIM_DEFAULT = 1023;

  localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_CODE   = 2'd0,
    MODE_BASE   = 2'd1,
    MODE_PLAYER = 2'd2,
    MODE_REPEAT = 2'd3
  } mode_e;

  // top two bits of a code byte
  typedef enum logic [1:0] {
    CLS_SKIP   = 2'd0,
    CLS_BASE   = 2'd1,
    CLS_PLAYER = 2'd2,
    CLS_REPEAT = 2'd3
  } code_class_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRANSPARENT = 2'd0,
    KIND_BASE        = 2'd1,
    KIND_PLAYER      = 2'd2
  } kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] stream_byte;
    logic              image_start;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] pixel_index;
    logic [KIND_W-1:0]    pixel_kind;
    logic [BYTE_W-1:0]    pixel_colour;
    logic                 out_of_range;
    logic                 run_last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/pcrd_ctrl.sv -----
// controller state machine of the run-length sprite decoder
module pcrd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pcrd_pkg::status_t status_i,
  output pcrd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  pcrd_pkg::cmd_t cmd;

  always_comb begin
    cmd        = '0;
    cmd.accept = (state_q == ST_IDLE) && in_valid_i;
    cmd.eval   = (state_q == ST_EVAL);
    cmd.emit   = (state_q == ST_EMIT) && !status_i.cnt_zero && status_i.out_free;
    cmd.finish = (state_q == ST_EMIT) &&
                 (status_i.cnt_zero || (cmd.emit && status_i.cnt_one));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd.accept) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.finish) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> state_q == ST_EVAL)
    else $error("accepted item did not move to evaluation");

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status_i.out_free && !status_i.cnt_zero)
    else $error("pixel issued without a free output slot");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> in_ready_o)
    else $error("controller not ready after finishing an item");
`endif

endmodule

// ----- hdl/pcrd_datapath.sv -----
// datapath of the run-length sprite decoder: config, decode state, pixel address and output
module pcrd_datapath #(
  parameter int unsigned MAX_DIM = pcrd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcrd_pkg::cmd_t                   cmd_i,
  output pcrd_pkg::status_t                status_o,
  input  pcrd_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pcrd_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [pcrd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcrd_pkg::DIM_W-1:0]       cfg_wdata_i
);

  localparam int unsigned ROW_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM + 1) : 1;
  localparam int unsigned BASE_W = ROW_W + pcrd_pkg::DIM_W;
  localparam int unsigned SUM_W  =
    ((BASE_W > pcrd_pkg::COL_W) ? BASE_W : pcrd_pkg::COL_W) + 1;
  localparam int unsigned CMP_W  =
    (SUM_W > pcrd_pkg::SIZE_W) ? SUM_W : pcrd_pkg::SIZE_W;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_DIM);

  logic [pcrd_pkg::DIM_W-1:0]    width_q, height_q;
  logic [pcrd_pkg::BYTE_W-1:0]   byte_q;
  logic                          start_q;
  pcrd_pkg::mode_e               mode_q, mode_d;
  logic [pcrd_pkg::RUN_W-1:0]    run_q, run_d;
  logic [pcrd_pkg::COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [pcrd_pkg::RUN_W-1:0]    cnt_q, cnt_d;
  logic                          end_pend_q, end_pend_d;
  logic                          out_valid_q;
  logic [BASE_W-1:0]             base_q;
  logic [pcrd_pkg::SIZE_W-1:0]   size_q;
  pcrd_pkg::kind_e               kind_q, kind_d;
  logic [pcrd_pkg::BYTE_W-1:0]   colour_q, colour_d;
  pcrd_pkg::out_item_t           out_q;

  // effective state once image_start is applied
  pcrd_pkg::mode_e               mode_eff;
  logic [pcrd_pkg::RUN_W-1:0]    run_eff, run_dec;
  logic [pcrd_pkg::COL_W-1:0]    col_eff, col_inc, col_nx;
  logic [ROW_W-1:0]              row_eff;
  pcrd_pkg::code_class_e         cls;
  logic [pcrd_pkg::RUN_W-1:0]    len;

  pcrd_pkg::mode_e               ev_mode;
  logic [pcrd_pkg::RUN_W-1:0]    ev_run, ev_cnt;
  pcrd_pkg::kind_e               ev_kind;
  logic [pcrd_pkg::BYTE_W-1:0]   ev_colour;
  logic                          ev_end;

  logic [CMP_W-1:0]              pix_idx;
  logic                          pix_oor;
  logic                          out_free;

  assign mode_eff = start_q ? pcrd_pkg::MODE_CODE : mode_q;
  assign run_eff  = start_q ? '0 : run_q;
  assign col_eff  = start_q ? '0 : col_q;
  assign row_eff  = start_q ? '0 : row_q;
  assign cls      = pcrd_pkg::code_class_e'(byte_q[7:6]);
  assign len      = byte_q[pcrd_pkg::RUN_W-1:0];
  assign run_dec  = run_eff - pcrd_pkg::RUN_W'(1);

  // decode of one item against the current mode
  always_comb begin
    ev_mode   = mode_eff;
    ev_run    = run_eff;
    ev_cnt    = '0;
    ev_kind   = pcrd_pkg::KIND_TRANSPARENT;
    ev_colour = byte_q;
    ev_end    = 1'b0;
    unique case (mode_eff)
      pcrd_pkg::MODE_CODE: begin
        unique case (cls)
          pcrd_pkg::CLS_SKIP: begin
            ev_cnt    = len;
            ev_colour = '0;
            ev_end    = 1'b1;
          end
          pcrd_pkg::CLS_BASE: begin
            ev_mode = pcrd_pkg::MODE_BASE;
            ev_run  = len;
            ev_end  = (len == '0);
          end
          pcrd_pkg::CLS_PLAYER: begin
            ev_mode = pcrd_pkg::MODE_PLAYER;
            ev_run  = len;
            ev_end  = (len == '0);
          end
          pcrd_pkg::CLS_REPEAT: begin
            ev_mode = pcrd_pkg::MODE_REPEAT;
            ev_run  = len;
          end
        endcase
      end
      pcrd_pkg::MODE_BASE, pcrd_pkg::MODE_PLAYER: begin
        ev_cnt  = pcrd_pkg::RUN_W'(1);
        ev_kind = (mode_eff == pcrd_pkg::MODE_BASE) ? pcrd_pkg::KIND_BASE
                                                     : pcrd_pkg::KIND_PLAYER;
        ev_run  = run_dec;
        ev_end  = (run_dec == '0);
      end
      pcrd_pkg::MODE_REPEAT: begin
        ev_cnt  = run_eff;
        ev_kind = pcrd_pkg::KIND_BASE;
        ev_end  = 1'b1;
      end
    endcase
  end

  assign col_inc = (col_q != pcrd_pkg::COL_MAX) ? col_q + pcrd_pkg::COL_W'(1) : col_q;
  assign col_nx  = cmd_i.emit ? col_inc : col_q;

  assign pix_idx  = CMP_W'(base_q) + CMP_W'(col_q);
  assign pix_oor  = (pix_idx >= CMP_W'(size_q));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mode_d     = mode_q;
    run_d      = run_q;
    col_d      = col_q;
    row_d      = row_q;
    cnt_d      = cnt_q;
    end_pend_d = end_pend_q;
    kind_d     = kind_q;
    colour_d   = colour_q;
    if (cmd_i.eval) begin
      mode_d     = ev_mode;
      run_d      = ev_run;
      col_d      = col_eff;
      row_d      = row_eff;
      cnt_d      = ev_cnt;
      end_pend_d = ev_end;
      kind_d     = ev_kind;
      colour_d   = ev_colour;
    end else begin
      if (cmd_i.emit) begin
        col_d = col_inc;
        cnt_d = cnt_q - pcrd_pkg::RUN_W'(1);
      end
      if (cmd_i.finish && end_pend_q) begin
        mode_d     = pcrd_pkg::MODE_CODE;
        run_d      = '0;
        end_pend_d = 1'b0;
        if (col_nx >= pcrd_pkg::COL_W'(width_q)) begin
          col_d = '0;
          if (row_q < ROW_LAST) row_d = row_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= '0;
      height_q    <= '0;
      start_q     <= 1'b0;
      mode_q      <= pcrd_pkg::MODE_CODE;
      run_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      end_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (pcrd_pkg::cfg_reg_e'(cfg_idx_i))
          pcrd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
          pcrd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        endcase
      end
      if (cmd_i.accept) start_q <= in_item_i.image_start;
      mode_q     <= mode_d;
      run_q      <= run_d;
      col_q      <= col_d;
      row_q      <= row_d;
      cnt_q      <= cnt_d;
      end_pend_q <= end_pend_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) byte_q <= in_item_i.stream_byte;
    if (cmd_i.eval) begin
      base_q <= BASE_W'(row_eff) * BASE_W'(width_q);
      size_q <= pcrd_pkg::SIZE_W'(width_q) * pcrd_pkg::SIZE_W'(height_q);
    end
    kind_q   <= kind_d;
    colour_q <= colour_d;
    if (cmd_i.emit) begin
      out_q.pixel_index  <= pix_idx[pcrd_pkg::IDX_OUT_W-1:0];
      out_q.pixel_kind   <= kind_q;
      out_q.pixel_colour <= colour_q;
      out_q.out_of_range <= pix_oor;
      out_q.run_last     <= (cnt_q == pcrd_pkg::RUN_W'(1));
    end
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cnt_one  = (cnt_q == pcrd_pkg::RUN_W'(1));
  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

`ifndef SYNTHESIS
  a_emit_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> cnt_q == $past(cnt_q) - pcrd_pkg::RUN_W'(1))
    else $error("pixel count did not step down after a pixel");

  a_run_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && end_pend_q) |=> mode_q == pcrd_pkg::MODE_CODE && run_q == '0)
    else $error("run end did not return to code mode");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_q))
    else $error("waiting pixel changed before it was taken");
`endif

endmodule

// ----- hdl/player_colour_rle_decoder.sv -----
// top level of the run-length sprite decoder with player-colour pixels
// an item is accepted in the idle cycle, decoded and its row base multiplied in the next,
// then gives one pixel per cycle while the output is not stalled, for n pixels per item (n up to 63)
// first pixel of an item is registered in the emit state that follows evaluation, once the output slot is free
// output stalls hold the pixel sequencer; the last pixel may wait while the next item is taken
// asynchronous active-low reset clears config, decode state, row and column; no clearing pass
module player_colour_rle_decoder #(
  parameter int unsigned MAX_DIM = pcrd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pcrd_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pcrd_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [pcrd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcrd_pkg::DIM_W-1:0]     cfg_wdata_i
);

  pcrd_pkg::cmd_t    cmd;
  pcrd_pkg::status_t status;

  pcrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcrd_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
